@@ rtl/kfas_pkg.sv @@
// Shared types and constants for the keyframe animation sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package kfas_pkg;

    localparam int MAX_ANIMATIONS = 16;
    localparam int IDX_W          = $clog2(MAX_ANIMATIONS);
    localparam int FRAME_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int FRAC_W         = 16;
    localparam int PROD_W         = TIME_BITS + FRAME_BITS;
    localparam int CNT_W          = $clog2((FRAME_BITS > FRAC_W) ? FRAME_BITS : FRAC_W);

    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEFINE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PLAY     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_QUEUE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_OVERRIDE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ANIM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic [FRAME_BITS-1:0] ent_first;
        logic [FRAME_BITS-1:0] ent_last;
        logic [TIME_BITS-1:0]  ent_len;
    } t_entry;

    typedef struct packed {
        logic              done;
        logic              step;
        logic [FRAC_W-1:0] acc;
    } t_blend_res;

endpackage

`default_nettype wire

@@ rtl/kfas_entry_table.sv @@
// Animation table: entry memory with one write and one registered read port,
// plus per-entry valid flags cleared by reset. Depends on kfas_pkg.
`default_nettype none

module kfas_entry_table (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_wr_en,
    input  wire [kfas_pkg::IDX_W-1:0]             i_wr_addr,
    input  wire kfas_pkg::t_entry                 i_wr_data,
    input  wire                                   i_rd_en,
    input  wire [kfas_pkg::IDX_W-1:0]             i_rd_addr,
    output kfas_pkg::t_entry                      o_rd_data,
    output logic [kfas_pkg::MAX_ANIMATIONS-1:0]   o_valid_mask
);
    import kfas_pkg::*;

    t_entry                    r_mem [MAX_ANIMATIONS];
    t_entry                    r_rd_data;
    logic [MAX_ANIMATIONS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_valid_mask = r_valid;

endmodule

`default_nettype wire

@@ rtl/kfas_blend_unit.sv @@
// Blend increment unit: bit-serial multiply dt*span, then restoring division
// of (product << 16) by the duration, one quotient bit per cycle. Depends on kfas_pkg.
`default_nettype none

module kfas_blend_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire [kfas_pkg::TIME_BITS-1:0]     i_dt,
    input  wire [kfas_pkg::FRAME_BITS-1:0]    i_diff,
    input  wire [kfas_pkg::TIME_BITS-1:0]     i_len,
    input  wire [kfas_pkg::FRAC_W-1:0]        i_acc,
    output kfas_pkg::t_blend_res              o_res
);
    import kfas_pkg::*;

    typedef enum logic [2:0] {U_IDLE, U_MUL, U_CMP, U_DIV, U_SUM} t_ustate;

    t_ustate                r_state;
    logic [TIME_BITS-1:0]   r_dt;
    logic [FRAME_BITS-1:0]  r_diff;
    logic [TIME_BITS-1:0]   r_len;
    logic [FRAC_W-1:0]      r_acc;
    logic [PROD_W-1:0]      r_prod;
    logic [TIME_BITS-1:0]   r_rem;
    logic [FRAC_W-1:0]      r_quo;
    logic [CNT_W-1:0]       r_cnt;
    t_blend_res             r_res;

    logic [PROD_W-1:0]      n_prod;
    logic [TIME_BITS:0]     rem_dbl;
    logic [TIME_BITS:0]     rem_sub;
    logic                   rem_ge;
    logic [FRAC_W:0]        acc_sum;

    // MSB first over the span bits: prod = 2*prod + (bit ? dt : 0)
    always_comb begin
        n_prod  = {r_prod[PROD_W-2:0], 1'b0}
                  + (r_diff[FRAME_BITS-1] ? PROD_W'(r_dt) : '0);
        rem_dbl = {r_rem, 1'b0};
        rem_ge  = rem_dbl >= {1'b0, r_len};
        rem_sub = rem_dbl - {1'b0, r_len};
        acc_sum = {1'b0, r_acc} + {1'b0, r_quo};
    end

    // done is a one-cycle pulse, cleared on the idle cycle after it is raised
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= U_IDLE;
            r_res.done <= 1'b0;
        end else begin
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_dt   <= i_dt;
                        r_diff <= i_diff;
                        r_len  <= i_len;
                        r_acc  <= i_acc;
                        r_prod <= '0;
                        r_cnt  <= CNT_W'(FRAME_BITS - 1);
                        if (i_dt == '0) begin
                            r_res <= '{done: 1'b1, step: 1'b0, acc: i_acc};
                        end else if (i_len == '0) begin
                            r_res <= '{done: 1'b1, step: 1'b1, acc: '0};
                        end else begin
                            r_res.done <= 1'b0;
                            r_state    <= U_MUL;
                        end
                    end else begin
                        r_res.done <= 1'b0;
                    end
                end
                U_MUL: begin
                    r_prod <= n_prod;
                    r_diff <= {r_diff[FRAME_BITS-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= U_CMP;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                U_CMP: begin
                    // product at or above the duration reaches one outright
                    if (r_prod >= PROD_W'(r_len)) begin
                        r_res   <= '{done: 1'b1, step: 1'b1, acc: '0};
                        r_state <= U_IDLE;
                    end else begin
                        r_rem   <= r_prod[TIME_BITS-1:0];
                        r_quo   <= '0;
                        r_cnt   <= CNT_W'(FRAC_W - 1);
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    if (rem_ge) begin
                        r_rem <= rem_sub[TIME_BITS-1:0];
                        r_quo <= {r_quo[FRAC_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_dbl[TIME_BITS-1:0];
                        r_quo <= {r_quo[FRAC_W-2:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_state <= U_SUM;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                U_SUM: begin
                    r_res   <= '{done: 1'b1, step: acc_sum[FRAC_W],
                                 acc: acc_sum[FRAC_W-1:0]};
                    r_state <= U_IDLE;
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

@@ rtl/keyframe_animation_sequencer_top.sv @@
// Keyframe animation sequencer top level: request decode and playback state.
// Depends on kfas_pkg, kfas_entry_table and kfas_blend_unit.
`default_nettype none

// One request is handled at a time and each gives exactly one result. A tick goes from
// input transfer to result through decode, a table read, a bit-serial multiply of dt by
// the frame span, a compare, a restoring division by the playing duration, a final add,
// taking up the blend result and loading the output register. A tick with a zero span
// skips the blend unit, with zero dt or zero duration the blend unit answers at once,
// and with a product at or past the duration it skips the division; a step onto a
// queued animation costs one more table read. Define, queue, override, unknown requests
// and a tick on an empty table go from decode to the output register; play of a defined
// entry that is not yet playing adds a table read. The next request can be taken while
// the result sits in the output register, which holds it until the output transfer;
// while it waits, the next result stalls the input.
module keyframe_animation_sequencer_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire [kfas_pkg::REQ_W-1:0]          i_req_type,
    input  wire [kfas_pkg::IDX_W-1:0]          i_anim_index,
    input  wire [kfas_pkg::FRAME_BITS-1:0]     i_start_frame,
    input  wire [kfas_pkg::FRAME_BITS-1:0]     i_end_frame,
    input  wire [kfas_pkg::TIME_BITS-1:0]      i_duration_us,
    input  wire [kfas_pkg::TIME_BITS-1:0]      i_dt_us,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [kfas_pkg::STAT_W-1:0]        o_status,
    output logic [kfas_pkg::FRAME_BITS-1:0]    o_shown_frame,
    output logic [kfas_pkg::FRAME_BITS-1:0]    o_following_frame,
    output logic [kfas_pkg::FRAC_W-1:0]        o_blend_fraction,
    output logic [kfas_pkg::IDX_W-1:0]         o_playing_entry,
    output logic                               o_frame_stepped
);
    import kfas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_RD_PLAY, S_RD_TICK, S_BLEND, S_RD_QUEUE, S_DONE
    } t_state;

    function automatic logic frame_wraps(input logic [FRAME_BITS-1:0] cur,
                                         input logic [FRAME_BITS-1:0] lim);
        frame_wraps = ({1'b0, cur} + 1'b1) > {1'b0, lim};
    endfunction

    t_state                 r_state;
    logic [REQ_W-1:0]       r_req;
    logic [IDX_W-1:0]       r_idx;
    logic [FRAME_BITS-1:0]  r_sf;
    logic [FRAME_BITS-1:0]  r_ef;
    logic [TIME_BITS-1:0]   r_dur;
    logic [TIME_BITS-1:0]   r_dt;
    logic [STAT_W-1:0]      r_status;
    logic                   r_stepped;
    logic [IDX_W-1:0]       r_playing;
    logic [IDX_W-1:0]       r_queued;
    logic                   r_qvalid;
    logic [TIME_BITS-1:0]   r_len;
    logic [FRAME_BITS-1:0]  r_now;
    logic [FRAME_BITS-1:0]  r_next;
    logic [FRAC_W-1:0]      r_blend;

    logic                   r_out_valid;
    logic [STAT_W-1:0]      r_out_status;
    logic [FRAME_BITS-1:0]  r_out_shown;
    logic [FRAME_BITS-1:0]  r_out_follow;
    logic [FRAC_W-1:0]      r_out_blend;
    logic [IDX_W-1:0]       r_out_entry;
    logic                   r_out_stepped;

    logic                   wr_en;
    t_entry                 wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    t_entry                 rd_data;
    logic [MAX_ANIMATIONS-1:0] valid_mask;
    logic [MAX_ANIMATIONS-1:0] others_mask;
    logic [FRAME_BITS-1:0]  def_last;
    logic [FRAME_BITS-1:0]  cur_diff;
    logic [FRAME_BITS:0]    step_nxt;
    logic                   step_wraps;
    logic                   blend_start;
    t_blend_res             blend_res;

    always_comb begin
        def_last    = (r_ef < r_sf) ? r_sf : r_ef;
        wr_en       = (r_state == S_DECODE) && (r_req == REQ_DEFINE);
        wr_data     = '{ent_first: r_sf, ent_last: def_last, ent_len: r_dur};
        // valid entries other than the one being defined
        others_mask = valid_mask & ~(MAX_ANIMATIONS'(1) << r_idx);
        cur_diff    = rd_data.ent_last - rd_data.ent_first;
        step_nxt    = {1'b0, r_next} + 1'b1;
        step_wraps  = step_nxt > {1'b0, rd_data.ent_last};
        blend_start = (r_state == S_RD_TICK) && (cur_diff != '0);
        rd_addr     = (r_state == S_DECODE)
                      ? ((r_req == REQ_TICK) ? r_playing : r_idx) : r_queued;
        // read data must hold the playing entry until the blend result is used
        rd_en       = ((r_state == S_DECODE) &&
                       ((r_req == REQ_TICK) || (r_req == REQ_PLAY))) ||
                      ((r_state == S_BLEND) && blend_res.done && blend_res.step &&
                       step_wraps && r_qvalid);
    end

    kfas_entry_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (r_idx),
        .i_wr_data    (wr_data),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_data    (rd_data),
        .o_valid_mask (valid_mask)
    );

    kfas_blend_unit u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (blend_start),
        .i_dt    (r_dt),
        .i_diff  (cur_diff),
        .i_len   (r_len),
        .i_acc   (r_blend),
        .o_res   (blend_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_playing   <= '0;
            r_queued    <= '0;
            r_qvalid    <= 1'b0;
            r_len       <= '0;
            r_now       <= '0;
            r_next      <= '0;
            r_blend     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded instead
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req     <= i_req_type;
                        r_idx     <= i_anim_index;
                        r_sf      <= i_start_frame;
                        r_ef      <= i_end_frame;
                        r_dur     <= i_duration_us;
                        r_dt      <= i_dt_us;
                        r_status  <= STAT_OK;
                        r_stepped <= 1'b0;
                        r_state   <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= S_DONE;
                    unique case (r_req)
                        REQ_DEFINE: begin
                            // first entry defined starts playing at once
                            if (others_mask == '0) begin
                                r_playing <= r_idx;
                                r_len     <= r_dur;
                                r_now     <= r_sf;
                                r_next    <= frame_wraps(r_sf, def_last) ? r_sf
                                                                         : r_sf + 1'b1;
                                r_blend   <= '0;
                            end
                        end
                        REQ_PLAY: begin
                            if (!valid_mask[r_idx]) begin
                                r_status <= STAT_NO_ANIM;
                            end else if (r_idx != r_playing) begin
                                r_state <= S_RD_PLAY;
                            end
                        end
                        REQ_QUEUE: begin
                            if (!valid_mask[r_idx]) begin
                                r_status <= STAT_NO_ANIM;
                            end else begin
                                r_queued <= r_idx;
                                r_qvalid <= 1'b1;
                            end
                        end
                        REQ_OVERRIDE: begin
                            r_len <= r_dur;
                        end
                        REQ_TICK: begin
                            if (valid_mask == '0) begin
                                r_status <= STAT_EMPTY;
                            end else begin
                                r_state <= S_RD_TICK;
                            end
                        end
                        default: begin
                            r_status <= STAT_OK;
                        end
                    endcase
                end
                S_RD_PLAY: begin
                    r_playing <= r_idx;
                    r_len     <= rd_data.ent_len;
                    r_now     <= rd_data.ent_first;
                    r_next    <= frame_wraps(rd_data.ent_first, rd_data.ent_last)
                                 ? rd_data.ent_first : rd_data.ent_first + 1'b1;
                    r_blend   <= '0;
                    r_qvalid  <= 1'b0;
                    r_state   <= S_DONE;
                end
                S_RD_TICK: begin
                    if (cur_diff == '0) begin
                        r_blend <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    if (blend_res.done) begin
                        r_state <= S_DONE;
                        if (blend_res.step) begin
                            r_blend   <= '0;
                            r_stepped <= 1'b1;
                            r_now     <= r_next;
                            if (!step_wraps) begin
                                r_next <= step_nxt[FRAME_BITS-1:0];
                            end else if (r_qvalid) begin
                                r_state <= S_RD_QUEUE;
                            end else begin
                                r_next <= rd_data.ent_first;
                            end
                        end else begin
                            r_blend <= blend_res.acc;
                        end
                    end
                end
                S_RD_QUEUE: begin
                    r_playing <= r_queued;
                    r_len     <= rd_data.ent_len;
                    r_next    <= rd_data.ent_first;
                    r_qvalid  <= 1'b0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_status;
                        r_out_shown   <= r_now;
                        r_out_follow  <= r_next;
                        r_out_blend   <= r_blend;
                        r_out_entry   <= r_playing;
                        r_out_stepped <= r_stepped;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_shown_frame     = r_out_shown;
    assign o_following_frame = r_out_follow;
    assign o_blend_fraction  = r_out_blend;
    assign o_playing_entry   = r_out_entry;
    assign o_frame_stepped   = r_out_stepped;

    a_blend_done_in_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blend_res.done |-> (r_state == S_BLEND))
        else $error("blend result outside blend wait");

    a_queued_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qvalid |-> valid_mask[r_queued])
        else $error("queued entry not defined");

    a_playing_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid_mask != '0) |-> valid_mask[r_playing])
        else $error("playing entry not defined");

    a_step_clears_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_stepped) |-> (r_blend == '0))
        else $error("frame step left a nonzero blend");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for keyframe_animation_sequencer_top.
// Depends on kfas_pkg and the sequencer RTL; a built-in playback predictor checks each result.
`timescale 1ns / 1ps

module tb_top;

    import kfas_pkg::*;

    localparam int CLK_PERIOD   = 2;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [FRAME_BITS-1:0] shown;
        logic [FRAME_BITS-1:0] following;
        logic [FRAC_W-1:0]     blend;
        logic [IDX_W-1:0]      playing;
        logic                  stepped;
    } t_playback;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [REQ_W-1:0]      i_req_type;
    logic [IDX_W-1:0]      i_anim_index;
    logic [FRAME_BITS-1:0] i_start_frame;
    logic [FRAME_BITS-1:0] i_end_frame;
    logic [TIME_BITS-1:0]  i_duration_us;
    logic [TIME_BITS-1:0]  i_dt_us;
    logic                  o_valid;
    logic                  i_ready;
    logic [STAT_W-1:0]     o_status;
    logic [FRAME_BITS-1:0] o_shown_frame;
    logic [FRAME_BITS-1:0] o_following_frame;
    logic [FRAC_W-1:0]     o_blend_fraction;
    logic [IDX_W-1:0]      o_playing_entry;
    logic                  o_frame_stepped;

    keyframe_animation_sequencer_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_anim_index      (i_anim_index),
        .i_start_frame     (i_start_frame),
        .i_end_frame       (i_end_frame),
        .i_duration_us     (i_duration_us),
        .i_dt_us           (i_dt_us),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_shown_frame     (o_shown_frame),
        .o_following_frame (o_following_frame),
        .o_blend_fraction  (o_blend_fraction),
        .o_playing_entry   (o_playing_entry),
        .o_frame_stepped   (o_frame_stepped)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predicted playback state
    t_entry                anim_table [MAX_ANIMATIONS];
    logic                  anim_defined [MAX_ANIMATIONS];
    logic [IDX_W-1:0]      cur_entry;
    logic [IDX_W-1:0]      queued_entry;
    logic                  queued_pending;
    logic [TIME_BITS-1:0]  cur_length_us;
    logic [FRAME_BITS-1:0] frame_shown;
    logic [FRAME_BITS-1:0] frame_following;
    logic [FRAC_W-1:0]     blend_now;

    t_playback playback_due [$];
    int        mismatch_count = 0;
    logic      tx_idle_on = 1'b1;
    logic      rx_stall_on = 1'b1;
    logic      rx_hold_req = 1'b0;

    function automatic void play_from_first(input logic [IDX_W-1:0] idx);
        logic [FRAME_BITS:0] nxt;
        cur_entry     = idx;
        cur_length_us = anim_table[idx].ent_len;
        frame_shown   = anim_table[idx].ent_first;
        nxt           = {1'b0, frame_shown} + 1'b1;
        frame_following = (nxt > {1'b0, anim_table[idx].ent_last}) ? frame_shown
                                                                     : nxt[FRAME_BITS-1:0];
        blend_now = '0;
    endfunction

    function automatic t_playback apply_request(
        input logic [REQ_W-1:0]      req,
        input logic [IDX_W-1:0]      idx,
        input logic [FRAME_BITS-1:0] first_f,
        input logic [FRAME_BITS-1:0] last_f,
        input logic [TIME_BITS-1:0]  dur,
        input logic [TIME_BITS-1:0]  dt
    );
        t_playback             res;
        int                    defined_cnt;
        logic [FRAME_BITS-1:0] span;
        logic [63:0]           prod;
        logic [63:0]           inc;
        logic                  reach;
        logic [FRAME_BITS:0]   nxt;
        logic [IDX_W-1:0]      p;
        res = '0;
        res.status = STAT_OK;
        defined_cnt = 0;
        for (int k = 0; k < MAX_ANIMATIONS; k++)
            if (anim_defined[k]) defined_cnt++;
        case (req)
            REQ_DEFINE: begin
                anim_table[idx].ent_first = first_f;
                anim_table[idx].ent_last  = (last_f < first_f) ? first_f : last_f;
                anim_table[idx].ent_len   = dur;
                if (!anim_defined[idx]) defined_cnt++;
                anim_defined[idx] = 1'b1;
                if (defined_cnt == 1) play_from_first(idx);
            end
            REQ_PLAY: begin
                if (!anim_defined[idx]) begin
                    res.status = STAT_NO_ANIM;
                end else if (idx != cur_entry) begin
                    play_from_first(idx);
                    queued_pending = 1'b0;
                end
            end
            REQ_QUEUE: begin
                if (!anim_defined[idx]) begin
                    res.status = STAT_NO_ANIM;
                end else begin
                    queued_entry   = idx;
                    queued_pending = 1'b1;
                end
            end
            REQ_OVERRIDE: cur_length_us = dur;
            REQ_TICK: begin
                if (defined_cnt == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    p    = cur_entry;
                    span = anim_table[p].ent_last - anim_table[p].ent_first;
                    reach = 1'b0;
                    if (span == 0) begin
                        blend_now = '0;
                    end else begin
                        if (dt == 0) begin
                            reach = 1'b0;
                        end else if (cur_length_us == 0) begin
                            reach = 1'b1;
                        end else begin
                            prod = 64'(dt) * 64'(span);
                            if (prod >= 64'(cur_length_us)) begin
                                reach = 1'b1;
                            end else begin
                                inc = (prod << 16) / 64'(cur_length_us);
                                if (64'(blend_now) + inc >= 64'd65536)
                                    reach = 1'b1;
                                else
                                    blend_now = blend_now + inc[FRAC_W-1:0];
                            end
                        end
                        if (reach) begin
                            blend_now   = '0;
                            res.stepped = 1'b1;
                            frame_shown = frame_following;
                            nxt = {1'b0, frame_following} + 1'b1;
                            frame_following = nxt[FRAME_BITS-1:0];
                            // ran off the end: wrap, or hand over to the queued entry
                            if (nxt > {1'b0, anim_table[p].ent_last}) begin
                                if (queued_pending) begin
                                    p              = queued_entry;
                                    cur_entry      = p;
                                    cur_length_us  = anim_table[p].ent_len;
                                    queued_pending = 1'b0;
                                end
                                frame_following = anim_table[p].ent_first;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.shown     = frame_shown;
        res.following = frame_following;
        res.blend     = blend_now;
        res.playing   = cur_entry;
        return res;
    endfunction

    task automatic send_request(
        input logic [REQ_W-1:0]      req,
        input logic [IDX_W-1:0]      idx,
        input logic [FRAME_BITS-1:0] first_f,
        input logic [FRAME_BITS-1:0] last_f,
        input logic [TIME_BITS-1:0]  dur,
        input logic [TIME_BITS-1:0]  dt
    );
        t_playback exp_res;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_anim_index  <= idx;
        i_start_frame <= first_f;
        i_end_frame   <= last_f;
        i_duration_us <= dur;
        i_dt_us       <= dt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        exp_res = apply_request(req, idx, first_f, last_f, dur, dt);
        playback_due.push_back(exp_res);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (playback_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int unsigned hold_count;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_count++;
                end
                rx_hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_playback exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (playback_due.size() == 0) begin
                $display("%0t: result transfer with nothing pending", $time);
                mismatch_count++;
            end else begin
                exp_res = playback_due.pop_front();
                check_field("status", 32'(exp_res.status), 32'(o_status));
                check_field("shown_frame", 32'(exp_res.shown), 32'(o_shown_frame));
                check_field("following_frame", 32'(exp_res.following),
                            32'(o_following_frame));
                check_field("blend_fraction", 32'(exp_res.blend), 32'(o_blend_fraction));
                check_field("playing_entry", 32'(exp_res.playing), 32'(o_playing_entry));
                check_field("frame_stepped", 32'(exp_res.stepped), 32'(o_frame_stepped));
            end
        end
    end

    task automatic test_empty_table();
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd5);
        send_request(REQ_PLAY, 4'd3, 16'd0, 16'd0, 32'd0, 32'd0);
        send_request(REQ_QUEUE, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_OVERRIDE, 4'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(3'd5, 4'd1, 16'd1, 16'd2, 32'd3, 32'd4);
        send_request(3'd7, 4'd2, 16'd5, 16'd6, 32'd7, 32'd8);
    endtask

    task automatic test_define_and_play();
        // end below start is clamped: a single-frame entry with zero span
        send_request(REQ_DEFINE, 4'd9, 16'd100, 16'd50, 32'd1000, 32'd0);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd500);
        send_request(REQ_DEFINE, 4'd0, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_PLAY, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    endtask

    task automatic test_zero_duration();
        send_request(REQ_OVERRIDE, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd1);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    endtask

    task automatic test_queue_and_wrap();
        send_request(REQ_DEFINE, 4'd15, 16'hFFFE, 16'hFFFF, 32'd10, 32'd0);
        send_request(REQ_PLAY, 4'd15, 16'd0, 16'd0, 32'd0, 32'd0);
        send_request(REQ_QUEUE, 4'd9, 16'd0, 16'd0, 32'd0, 32'd0);
        // stepping onto the top frame hands over to the queued entry
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd10);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd1);
        send_request(REQ_PLAY, 4'd15, 16'd0, 16'd0, 32'd0, 32'd0);
        send_request(REQ_PLAY, 4'd15, 16'd0, 16'd0, 32'd0, 32'd0);
        // floored increments sum to 65535, just short of one
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd3);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd7);
        send_request(REQ_TICK, 4'd0, 16'd0, 16'd0, 32'd0, 32'd1);
    endtask

    task automatic send_random_request();
        logic [REQ_W-1:0]      req;
        logic [IDX_W-1:0]      idx;
        logic [FRAME_BITS-1:0] first_f;
        logic [FRAME_BITS-1:0] last_f;
        logic [TIME_BITS-1:0]  dur;
        logic [TIME_BITS-1:0]  dt;
        int                    pick;
        int                    shape;
        idx     = IDX_W'($urandom_range(0, MAX_ANIMATIONS - 1));
        first_f = FRAME_BITS'($urandom);
        last_f  = FRAME_BITS'($urandom);
        dur     = $urandom;
        dt      = $urandom;
        pick    = $urandom_range(0, 99);
        shape   = $urandom_range(0, 9);
        if (pick < 52) begin
            req = REQ_TICK;
            if (shape == 0)      dt = '0;
            else if (shape < 7)  dt = $urandom_range(1, 600);
            else if (shape < 9)  dt = $urandom_range(0, 4000);
        end else if (pick < 64) begin
            req = REQ_DEFINE;
            if (shape < 7)       last_f = first_f + FRAME_BITS'($urandom_range(0, 4));
            else if (shape == 9) last_f = first_f;
            if ($urandom_range(0, 4) != 0) dur = $urandom_range(0, 2000);
        end else if (pick < 74) begin
            req = REQ_PLAY;
        end else if (pick < 84) begin
            req = REQ_QUEUE;
        end else if (pick < 94) begin
            req = REQ_OVERRIDE;
            if (shape < 7)       dur = $urandom_range(0, 2000);
            else if (shape == 7) dur = '0;
        end else begin
            req = REQ_W'($urandom_range(5, 7));
        end
        send_request(req, idx, first_f, last_f, dur, dt);
    endtask

    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        repeat (8) send_random_request();
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                tx_idle_on  = ($urandom_range(0, 2) != 0);
                rx_stall_on = ($urandom_range(0, 2) != 0);
            end
            if (n >= RANDOM_ITEMS - 100) begin
                tx_idle_on  = 1'b0;
                rx_stall_on = 1'b0;
            end
            if (n == RANDOM_ITEMS / 2) wait_results_drained();
            send_random_request();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = REQ_TICK;
        i_anim_index  = '0;
        i_start_frame = '0;
        i_end_frame   = '0;
        i_duration_us = '0;
        i_dt_us       = '0;
        for (int k = 0; k < MAX_ANIMATIONS; k++) begin
            anim_table[k]   = '0;
            anim_defined[k] = 1'b0;
        end
        cur_entry       = '0;
        queued_entry    = '0;
        queued_pending  = 1'b0;
        cur_length_us   = '0;
        frame_shown     = '0;
        frame_following = '0;
        blend_now       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_define_and_play();
        test_zero_duration();
        test_queue_and_wrap();
        test_backpressure();
        test_random_traffic();
        wait_results_drained();

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kfas_pkg.sv
rtl/kfas_entry_table.sv
rtl/kfas_blend_unit.sv
rtl/keyframe_animation_sequencer_top.sv
tb/tb_top.sv
